### hw/rtl/opr_pkg.sv
// Shared constants and control types for the optimal page replacement block.
`timescale 1ns / 1ps

package opr_pkg;

    localparam int DEF_MAX_REFS   = 32;
    localparam int DEF_NUM_FRAMES = 4;
    localparam int DEF_PAGE_BITS  = 16;

    // Configuration register: frames_in_use
    localparam int               CFG_W     = 3;
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;

    // Fixed widths of the result word fields
    localparam int POS_W       = 5;
    localparam int FRAME_OUT_W = 2;
    localparam int TOTAL_W     = 6;

    // Commands from the replay sequencer to the frame table
    typedef struct packed {
        logic clear;       // empty all frames
        logic scan_clear;  // forget next-use marks before a scan
        logic scan_en;     // mark frames whose page matches the read word
        logic fill;        // load the victim frame with the faulting page
    } ft_ctrl_t;

    // Status from the frame table
    typedef struct packed {
        logic hit;         // compared page sits in an active frame
        logic all_found;   // every active frame has a next use marked
    } ft_stat_t;

endpackage

### hw/rtl/opr_if.sv
// Valid/ready channel interfaces for reference input and result output words.
`timescale 1ns / 1ps

interface opr_in_if #(
    parameter int PAGE_BITS = opr_pkg::DEF_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 last_ref;

    modport source (output valid, output page, output last_ref, input ready);
    modport sink   (input valid, input page, input last_ref, output ready);
endinterface

interface opr_out_if #(
    parameter int PAGE_BITS = opr_pkg::DEF_PAGE_BITS
);
    logic                            valid;
    logic                            ready;
    logic [opr_pkg::POS_W-1:0]       position;
    logic [PAGE_BITS-1:0]            ref_page;
    logic                            fault;
    logic [opr_pkg::FRAME_OUT_W-1:0] frame_written;
    logic [opr_pkg::TOTAL_W-1:0]     fault_total;
    logic                            last_result;

    modport source (output valid, output position, output ref_page, output fault,
                    output frame_written, output fault_total, output last_result,
                    input ready);
    modport sink   (input valid, input position, input ref_page, input fault,
                    input frame_written, input fault_total, input last_result,
                    output ready);
endinterface

### hw/rtl/optimal_page_replacement.sv
// Top level: reference string store and replay sequencer for optimal paging.
`timescale 1ns / 1ps

// Usage
//   refs    : input words {page, last_ref}, one per accepted handshake. Words
//             with last_ref low are stored in order; a word with last_ref high
//             is stored too and starts the replay. Words past MAX_REFS are
//             dropped, but last_ref on a dropped word still starts the replay.
//   results : one word per stored reference, in string order: position,
//             ref_page, fault, frame_written, fault_total, last_result.
//   cfg_we / cfg_wdata : write frames_in_use (0 acts as 1, values above
//             NUM_FRAMES act as NUM_FRAMES). Write only while idle.
// Timing
//   Loading takes one word per cycle. During replay refs.ready stays low.
//   A hit passes through memory read, compare and output load. A fault adds
//   a scan of the rest of the string, one stored word per cycle, and a frame
//   update. The scan stops early once every active frame has a next use
//   marked.
// Reset and stall
//   Reset empties the frames, clears the counts and sets frames_in_use to 3;
//   the reference memory holds no reset value and is read only where loaded.
//   A stalled receiver holds the sequencer with the result word in the output
//   register; refs is taken again once the final result has been loaded there.
module optimal_page_replacement #(
    parameter int MAX_REFS   = opr_pkg::DEF_MAX_REFS,
    parameter int NUM_FRAMES = opr_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = opr_pkg::DEF_PAGE_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [opr_pkg::CFG_W-1:0] cfg_wdata,
    opr_in_if.sink                    refs,
    opr_out_if.source                 results
);

    localparam int ADDR_W      = $clog2(MAX_REFS);
    localparam int CNT_W       = $clog2(MAX_REFS + 1);
    localparam int FRAME_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int POS_W       = opr_pkg::POS_W;
    localparam int FRAME_OUT_W = opr_pkg::FRAME_OUT_W;
    localparam int TOTAL_W     = opr_pkg::TOTAL_W;
    localparam int CFG_W       = opr_pkg::CFG_W;

    typedef enum logic [2:0] {
        S_LOAD,   // take input words into the reference memory
        S_FETCH,  // read the reference at the replay position
        S_CHECK,  // compare it against the frames
        S_SCAN,   // walk the rest of the string for next uses
        S_PICK,   // load the victim frame
        S_PUT     // hand the result word to the output register
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     load_cnt_reg, load_cnt_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]    scan_reg, scan_next;
    logic [PAGE_BITS-1:0] pg_reg, pg_next;
    logic [CNT_W-1:0]     fault_cnt_reg, fault_cnt_next;
    logic                 res_fault_reg, res_fault_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;

    logic                   out_valid_reg, out_valid_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic [PAGE_BITS-1:0]   out_page_reg, out_page_next;
    logic                   out_fault_reg, out_fault_next;
    logic [FRAME_OUT_W-1:0] out_frame_reg, out_frame_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;
    logic                   out_last_reg, out_last_next;

    // Reference memory, one write and one registered read port
    logic [PAGE_BITS-1:0] ref_mem [MAX_REFS];
    logic [PAGE_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;

    opr_pkg::ft_ctrl_t     ft_ctrl;
    opr_pkg::ft_stat_t     ft_stat;
    logic [NUM_FRAMES-1:0] active;
    logic [FRAME_W-1:0]    hit_idx;
    logic [FRAME_W-1:0]    victim;
    logic                  last_pos;
    logic                  scan_more;

    // Frames that take part: frames_in_use clamped to 1..NUM_FRAMES
    always_comb
    begin
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            active[f] = (f == 0) || (f < int'(cfg_reg));
        end
    end

    opr_frame_table #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_W    (FRAME_W)
    ) u_frames (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ft_ctrl),
        .active    (active),
        .page      (rd_data_reg),
        .fill_page (pg_reg),
        .stat      (ft_stat),
        .hit_idx   (hit_idx),
        .victim    (victim)
    );

    assign last_pos  = (CNT_W'(pos_reg) + CNT_W'(1)) == load_cnt_reg;
    assign scan_more = (CNT_W'(scan_reg) + CNT_W'(1)) < load_cnt_reg;

    assign refs.ready = (state_reg == S_LOAD);

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        pos_next       = pos_reg;
        scan_next      = scan_reg;
        pg_next        = pg_reg;
        fault_cnt_next = fault_cnt_reg;
        res_fault_next = res_fault_reg;
        res_frame_next = res_frame_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_pos_next   = out_pos_reg;
        out_page_next  = out_page_reg;
        out_fault_next = out_fault_reg;
        out_frame_next = out_frame_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;
        ft_ctrl        = '0;
        rd_en          = 1'b0;
        rd_addr        = pos_reg;
        wr_en          = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (refs.valid)
                begin
                    // drop words once the store is full
                    if (load_cnt_reg < CNT_W'(MAX_REFS))
                    begin
                        wr_en         = 1'b1;
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                    if (refs.last_ref)
                    begin
                        ft_ctrl.clear  = 1'b1;
                        fault_cnt_next = '0;
                        pos_next       = '0;
                        state_next     = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = pos_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                pg_next = rd_data_reg;
                if (ft_stat.hit)
                begin
                    res_fault_next = 1'b0;
                    res_frame_next = hit_idx;
                    state_next     = S_PUT;
                end
                else
                begin
                    ft_ctrl.scan_clear = 1'b1;
                    scan_next          = pos_reg;
                    if ((CNT_W'(pos_reg) + CNT_W'(1)) < load_cnt_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = pos_reg + ADDR_W'(1);
                        scan_next  = pos_reg + ADDR_W'(1);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_PICK;
                    end
                end
            end
            S_SCAN:
            begin
                // rd_data_reg holds the word at scan_reg
                ft_ctrl.scan_en = 1'b1;
                if (ft_stat.all_found || !scan_more)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = scan_reg + ADDR_W'(1);
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            S_PICK:
            begin
                ft_ctrl.fill   = 1'b1;
                fault_cnt_next = fault_cnt_reg + CNT_W'(1);
                res_fault_next = 1'b1;
                res_frame_next = victim;
                state_next     = S_PUT;
            end
            S_PUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = POS_W'(pos_reg);
                    out_page_next  = pg_reg;
                    out_fault_next = res_fault_reg;
                    out_frame_next = FRAME_OUT_W'(res_frame_reg);
                    out_total_next = TOTAL_W'(fault_cnt_reg);
                    out_last_next  = last_pos;
                    if (last_pos)
                    begin
                        load_cnt_next = '0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        pos_next   = pos_reg + ADDR_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cfg_reg       <= opr_pkg::CFG_RESET;
            load_cnt_reg  <= '0;
            pos_reg       <= '0;
            scan_reg      <= '0;
            pg_reg        <= '0;
            fault_cnt_reg <= '0;
            res_fault_reg <= 1'b0;
            res_frame_reg <= '0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_page_reg  <= '0;
            out_fault_reg <= 1'b0;
            out_frame_reg <= '0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            load_cnt_reg  <= load_cnt_next;
            pos_reg       <= pos_next;
            scan_reg      <= scan_next;
            pg_reg        <= pg_next;
            fault_cnt_reg <= fault_cnt_next;
            res_fault_reg <= res_fault_next;
            res_frame_reg <= res_frame_next;
            out_valid_reg <= out_valid_next;
            out_pos_reg   <= out_pos_next;
            out_page_reg  <= out_page_next;
            out_fault_reg <= out_fault_next;
            out_frame_reg <= out_frame_next;
            out_total_reg <= out_total_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[load_cnt_reg[ADDR_W-1:0]] <= refs.page;
        end
        if (rd_en)
        begin
            rd_data_reg <= ref_mem[rd_addr];
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.position      = out_pos_reg;
    assign results.ref_page      = out_page_reg;
    assign results.fault         = out_fault_reg;
    assign results.frame_written = out_frame_reg;
    assign results.fault_total   = out_total_reg;
    assign results.last_result   = out_last_reg;

    // The scan never reads past the loaded string
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(scan_reg) < load_cnt_reg))
        else $error("scan address beyond loaded string");

    // Faults so far never exceed references replayed so far
    a_fault_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> (fault_cnt_reg <= (CNT_W'(pos_reg) + CNT_W'(1))))
        else $error("fault count exceeds replay position");

    // A hit goes straight to output and leaves the fault count alone
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && ft_stat.hit) |=>
            (state_reg == S_PUT && $stable(fault_cnt_reg) && !res_fault_reg))
        else $error("hit handled as fault");

    // A pick always counts one fault
    a_pick_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |=>
            (fault_cnt_reg == $past(fault_cnt_reg) + CNT_W'(1) && res_fault_reg))
        else $error("fault not counted on frame load");

endmodule

### hw/rtl/opr_frame_table.sv
// Frame table: resident pages, hit compare, next-use marks and victim choice.
`timescale 1ns / 1ps

module opr_frame_table #(
    parameter int NUM_FRAMES = opr_pkg::DEF_NUM_FRAMES,
    parameter int PAGE_BITS  = opr_pkg::DEF_PAGE_BITS,
    parameter int FRAME_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  opr_pkg::ft_ctrl_t     ctrl,
    input  logic [NUM_FRAMES-1:0] active,
    input  logic [PAGE_BITS-1:0]  page,
    input  logic [PAGE_BITS-1:0]  fill_page,
    output opr_pkg::ft_stat_t     stat,
    output logic [FRAME_W-1:0]    hit_idx,
    output logic [FRAME_W-1:0]    victim
);

    logic [PAGE_BITS-1:0]  frame_page_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [NUM_FRAMES-1:0] valid_next;
    logic [NUM_FRAMES-1:0] found_reg;
    logic [NUM_FRAMES-1:0] found_next;
    logic [FRAME_W-1:0]    last_reg;
    logic [FRAME_W-1:0]    last_next;

    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] fresh;
    logic [NUM_FRAMES-1:0] cand;
    logic [FRAME_W-1:0]    fresh_idx;
    logic [FRAME_W-1:0]    cand_idx;

    always_comb
    begin
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            match[f] = active[f] && valid_reg[f] && (frame_page_reg[f] == page);
        end
        fresh = match & ~found_reg;
        // found implies valid, so an unmarked active frame is furthest ahead
        cand  = active & ~found_reg;

        hit_idx   = '0;
        fresh_idx = '0;
        cand_idx  = '0;
        for (int f = NUM_FRAMES - 1; f >= 0; f--)
        begin
            if (match[f])
            begin
                hit_idx = FRAME_W'(f);
            end
            if (fresh[f])
            begin
                fresh_idx = FRAME_W'(f);
            end
            if (cand[f])
            begin
                cand_idx = FRAME_W'(f);
            end
        end

        stat.hit       = |match;
        stat.all_found = ((found_reg | fresh) & active) == active;
        victim         = (|cand) ? cand_idx : last_reg;

        valid_next = valid_reg;
        found_next = found_reg;
        last_next  = last_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        if (ctrl.scan_clear)
        begin
            found_next = '0;
            last_next  = '0;
        end
        else if (ctrl.scan_en && (|fresh))
        begin
            found_next = found_reg | fresh;
            last_next  = fresh_idx;
        end
        if (ctrl.fill)
        begin
            valid_next[victim] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            found_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            found_reg <= found_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.fill)
        begin
            frame_page_reg[victim] <= fill_page;
        end
    end

endmodule

### tb/sv/opr_checker.sv
// Checker that predicts optimal page replacement results and compares them on the result channel.
`timescale 1ns / 1ps

module opr_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [opr_pkg::CFG_W-1:0] cfg_wdata,
    opr_in_if                         refs,
    opr_out_if                        results,
    output int                        fail_count,
    output int                        outstanding,
    output int                        checked
);

    localparam int NEVER_AGAIN = 32'h7FFF_FFFF;
    localparam int PAGE_BITS   = opr_pkg::DEF_PAGE_BITS;
    localparam int MAX_REFS    = opr_pkg::DEF_MAX_REFS;
    localparam int NUM_FRAMES  = opr_pkg::DEF_NUM_FRAMES;
    localparam int POS_W       = opr_pkg::POS_W;
    localparam int FRAME_OUT_W = opr_pkg::FRAME_OUT_W;
    localparam int TOTAL_W     = opr_pkg::TOTAL_W;
    localparam int CFG_W       = opr_pkg::CFG_W;

    typedef struct {
        logic [POS_W-1:0]       position;
        logic [PAGE_BITS-1:0]   ref_page;
        logic                   fault;
        logic [FRAME_OUT_W-1:0] frame_written;
        logic [TOTAL_W-1:0]     fault_total;
        logic                   last_result;
    } page_result_t;

    logic [PAGE_BITS-1:0] loaded_pages [MAX_REFS];
    int                   loaded_count;
    logic [CFG_W-1:0]     frames_reg;
    logic [PAGE_BITS-1:0] frame_page [NUM_FRAMES];
    bit                   frame_live [NUM_FRAMES];
    page_result_t         predicted_results [$];

    // Position of the next reference to the page held in frame f, after pos.
    function automatic int next_reference(input int f, input int pos);
        if (!frame_live[f])
            return NEVER_AGAIN;
        for (int k = pos + 1; k < loaded_count; k++)
            if (loaded_pages[k] == frame_page[f])
                return k;
        return NEVER_AGAIN;
    endfunction

    // Replay the loaded string from empty frames and queue one result per entry.
    task automatic replay_string();
        int           active;
        int           victim;
        int           victim_dist;
        int           reach;
        int           faults;
        bit           hit;
        page_result_t r;
        active = frames_reg;
        if (active < 1)
            active = 1;
        if (active > NUM_FRAMES)
            active = NUM_FRAMES;
        foreach (frame_live[f])
            frame_live[f] = 1'b0;
        faults = 0;
        for (int i = 0; i < loaded_count; i++)
        begin
            hit    = 1'b0;
            victim = 0;
            for (int f = 0; f < active && !hit; f++)
            begin
                if (frame_live[f] && frame_page[f] == loaded_pages[i])
                begin
                    hit    = 1'b1;
                    victim = f;
                end
            end
            if (!hit)
            begin
                victim_dist = next_reference(0, i);
                for (int f = 1; f < active; f++)
                begin
                    reach = next_reference(f, i);
                    if (reach > victim_dist)
                    begin
                        victim_dist = reach;
                        victim      = f;
                    end
                end
                frame_page[victim] = loaded_pages[i];
                frame_live[victim] = 1'b1;
                faults++;
            end
            r.position      = POS_W'(i);
            r.ref_page      = loaded_pages[i];
            r.fault         = !hit;
            r.frame_written = FRAME_OUT_W'(victim);
            r.fault_total   = TOTAL_W'(faults);
            r.last_result   = (i == loaded_count - 1);
            predicted_results.push_back(r);
        end
        loaded_count = 0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            loaded_count = 0;
            frames_reg   = opr_pkg::CFG_RESET;
            predicted_results.delete();
            fail_count   = 0;
            outstanding  = 0;
            checked      = 0;
        end
        else
        begin
            if (cfg_we)
                frames_reg = cfg_wdata;
            if (refs.valid && refs.ready)
            begin
                if (loaded_count < MAX_REFS)
                begin
                    loaded_pages[loaded_count] = refs.page;
                    loaded_count++;
                end
                if (refs.last_ref)
                    replay_string();
            end
            if (results.valid && results.ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $error("result word at position %0d with none expected",
                           results.position);
                    fail_count++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    compare_field("position", want.position, results.position);
                    compare_field("ref_page", want.ref_page, results.ref_page);
                    compare_field("fault", want.fault, results.fault);
                    compare_field("frame_written", want.frame_written,
                                  results.frame_written);
                    compare_field("fault_total", want.fault_total, results.fault_total);
                    compare_field("last_result", want.last_result, results.last_result);
                    checked++;
                end
            end
            outstanding = predicted_results.size();
        end
    end

endmodule

### tb/sv/tb.sv
// Testbench top: reference string stimulus, result stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int PAGE_BITS = opr_pkg::DEF_PAGE_BITS;
    localparam int MAX_REFS  = opr_pkg::DEF_MAX_REFS;
    localparam int CFG_W     = opr_pkg::CFG_W;

    typedef logic [PAGE_BITS-1:0] page_t;

    // Random words to send after the directed strings.
    localparam int WORD_TARGET = 430;
    // Cycles to let the block settle once the last result word has left.
    localparam int SETTLE      = 8;
    // Worst case is far below this: ~460 words, each result at most a full
    // scan plus a long receiver stall, each word a long sender gap.
    localparam int CYCLE_LIMIT = 600_000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    opr_in_if  refs_ch ();
    opr_out_if res_ch ();

    int       fail_count;
    int       outstanding;
    int       checked;
    int       cycles;
    int       words_sent;
    int       strings_sent;
    bit       calm;
    bit [7:0] settings_used;

    optimal_page_replacement u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .refs      (refs_ch),
        .results   (res_ch)
    );

    opr_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .refs        (refs_ch),
        .results     (res_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // 10 ns clock, low first so the first edge sees reset already low.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pause_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    // Receiver: alternate bursts of ready with stalls. While calm is set the
    // stalls drop out, so some stretches run with ready held high.
    initial
    begin
        int burst;
        int hold;
        res_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            burst = $urandom_range(1, 24);
            res_ch.ready <= 1'b1;
            repeat (burst) @(posedge clk);
            hold = calm ? 0 : pause_length();
            if (hold > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Present one reference word and hold it until the block takes it. Valid
    // stays high on return unless a gap follows, so back-to-back words need
    // only one assignment per edge.
    task automatic send_word(input page_t pg, input bit last);
        int gap;
        refs_ch.valid    <= 1'b1;
        refs_ch.page     <= pg;
        refs_ch.last_ref <= last;
        @(posedge clk);
        while (!refs_ch.ready)
            @(posedge clk);
        words_sent++;
        gap = calm ? 0 : pause_length();
        if (gap > 0)
        begin
            // Drop valid and scramble the payload while idle.
            refs_ch.valid    <= 1'b0;
            refs_ch.page     <= page_t'($urandom);
            refs_ch.last_ref <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send a whole string; the final word carries last_ref.
    task automatic send_pages(input page_t pages [$]);
        for (int i = 0; i < pages.size(); i++)
            send_word(pages[i], i == pages.size() - 1);
        strings_sent++;
    endtask

    // Hold the sender until every predicted word has come back, then let the
    // block settle before anything else happens.
    task automatic wait_idle();
        refs_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write frames_in_use only once the block is idle.
    task automatic set_frames(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used[value] = 1'b1;
    endtask

    // Random string: mostly pages drawn from a small pool so hits and real
    // eviction choices occur, sometimes fully random pages. Lengths are mostly
    // short, with some full-store strings and some that overflow the store.
    task automatic send_random_string(input bit overflow);
        page_t pool [7];
        page_t pages [$];
        int    len;
        int    pool_n;
        int    r;
        bit    noisy;
        r = $urandom_range(0, 99);
        if (overflow || r >= 95)
            len = $urandom_range(MAX_REFS + 1, MAX_REFS + 8);
        else if (r < 70)
            len = $urandom_range(1, 12);
        else if (r < 88)
            len = $urandom_range(13, MAX_REFS - 1);
        else
            len = MAX_REFS;
        noisy  = overflow || ($urandom_range(0, 3) == 0);
        pool_n = $urandom_range(1, 7);
        foreach (pool[k])
            pool[k] = page_t'($urandom);
        for (int i = 0; i < len; i++)
            pages.push_back(noisy ? page_t'($urandom) : pool[$urandom_range(0, pool_n - 1)]);
        send_pages(pages);
    endtask

    initial
    begin
        page_t pq [$];
        int    phase;
        int    directed_words;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        refs_ch.valid    = 1'b0;
        refs_ch.page     = '0;
        refs_ch.last_ref = 1'b0;
        calm             = 1'b0;
        settings_used    = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset setting of three frames first.
        settings_used[opr_pkg::CFG_RESET] = 1'b1;
        // A string of one word, top page value.
        pq = '{16'hFFFF};
        send_pages(pq);
        // Textbook string: hits, faults and look-ahead eviction.
        pq = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd1, 16'd2, 16'd5, 16'd1, 16'd2, 16'd3,
               16'd4, 16'd5};
        send_pages(pq);
        // Zero frames acts as one frame.
        set_frames(3'd0);
        pq = '{16'h0000, 16'h0000, 16'h0001, 16'h0000};
        send_pages(pq);
        // Seven acts as all four frames; empty and never-again ties go low.
        set_frames(3'd7);
        pq = '{16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h5555, 16'h8000};
        send_pages(pq);
        directed_words = words_sent;

        // Random phases: sweep every frame setting once, then pick at random.
        // Every fourth phase runs with no idling on either side.
        phase = 0;
        while (words_sent < directed_words + WORD_TARGET)
        begin
            set_frames(phase < 8 ? CFG_W'((phase * 5 + 4) % 8)
                                 : CFG_W'($urandom_range(0, 7)));
            calm = (phase % 4 == 2);
            repeat ($urandom_range(2, 6))
            begin
                send_random_string(phase == 0);
                // Now and then drain the block between strings.
                if ($urandom_range(0, 4) == 0)
                    wait_idle();
            end
            phase++;
        end
        calm = 1'b0;
        wait_idle();

        $display("Sent %0d reference strings (%0d words, overflow past %0d included),",
                 strings_sent, words_sent, MAX_REFS);
        $display("%0d results checked; frame settings used: %0d of 8, stalls on both sides.",
                 checked, $countones(settings_used));
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/opr_pkg.sv
hw/rtl/opr_if.sv
hw/rtl/opr_frame_table.sv
hw/rtl/optimal_page_replacement.sv
tb/sv/opr_checker.sv
tb/sv/tb.sv
